FILE: rtl/core/generational_handle_allocator_unit_macros.svh
// Assertion macros for the handle allocator.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define GHAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("handle allocator assertion failed");

`define GHAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle allocator implication failed");

`else

`define GHAU_ASSERT(lbl, prop)

`define GHAU_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/gha_pkg.sv
package gha_pkg;

  localparam int MaxIds = 1024;
  localparam int IdW    = $clog2(MaxIds);
  localparam int CntW   = IdW + 1;
  localparam int VerW   = 16;
  localparam int OpW    = 2;
  localparam int StW    = 2;
  localparam int DataW  = ((IdW + VerW + 7) / 8) * 8;

  localparam logic [CntW-1:0] MaxCount = CntW'(MaxIds);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);

  typedef enum logic [OpW-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_VALIDATE = 2'd2
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Which result the datapath forms when the controller loads the output
  typedef enum logic [2:0] {
    RES_BAD   = 3'd0,
    RES_EMPTY = 3'd1,
    RES_FRESH = 3'd2,
    RES_POP   = 3'd3,
    RES_CHECK = 3'd4
  } res_e;

  typedef struct packed {
    logic capture;
    logic stack_rd;
    logic ver_rd_pop;
    logic ver_rd_id;
    logic res_load;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           stack_empty;
    logic           fresh_avail;
    logic           issued;
    logic           out_free;
  } stat_t;

endpackage

FILE: rtl/core/generational_handle_allocator_unit.sv
// Generational handle allocator.
// Slave channel s_axis: one request a beat; tuser carries the opcode (allocate,
// free, validate), tdata the handle (id, version) for free and validate.
// Master channel m_axis: one response a beat for every request; tuser carries
// the status (ok, stale or unknown, no id left), tdata the id and its version.
// A request is captured and decoded, then its response is loaded into the output
// register; an allocate that pops the free stack also passes a stack step, since
// the stack read and the version read are two dependent registered reads of the
// on-chip memories. A new request is taken once the previous result is loaded,
// while the previous response still waits.
// Reset clears the free stack count and the fresh id counter; no memory
// clearing pass runs, as a fresh id gets its version entry written as issued.
// When the receiver stalls, the response holds in the output register and the
// next request is worked up to its result, then waits for the register.
`include "generational_handle_allocator_unit_macros.svh"

module generational_handle_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [gha_pkg::DataW-1:0]   s_axis_tdata_i,  // handle_id, handle_version
  input  logic [gha_pkg::OpW-1:0]     s_axis_tuser_i,  // opcode
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [gha_pkg::DataW-1:0]   m_axis_tdata_o,  // id_out, version_out
  output logic [gha_pkg::StW-1:0]     m_axis_tuser_o   // status
);

  gha_pkg::cmd_t            cmd;
  gha_pkg::stat_t           stat;
  logic [gha_pkg::IdW-1:0]  out_id;
  logic [gha_pkg::VerW-1:0] out_ver;

  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gha_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (s_axis_tuser_i),
    .in_id_i      (s_axis_tdata_i[gha_pkg::IdW-1:0]),
    .in_ver_i     (s_axis_tdata_i[gha_pkg::IdW +: gha_pkg::VerW]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_id_o     (out_id),
    .out_ver_o    (out_ver)
  );

  assign m_axis_tdata_o = {{(gha_pkg::DataW - gha_pkg::IdW - gha_pkg::VerW){1'b0}},
                           out_ver, out_id};

  `GHAU_ASSERT_IMP(a_busy_after_take, s_axis_tvalid_i && s_axis_tready_o, ##1 !s_axis_tready_o)
  `GHAU_ASSERT_IMP(a_load_only_when_free, cmd.res_load, stat.out_free)
  `GHAU_ASSERT(a_one_read_at_a_time, $onehot0({cmd.stack_rd, cmd.ver_rd_pop, cmd.ver_rd_id}))
  `GHAU_ASSERT_IMP(a_load_raises_valid, cmd.res_load, ##1 m_axis_tvalid_o)

endmodule

FILE: rtl/core/gha_ram.sv
module gha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/gha_dp.sv
module gha_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gha_pkg::cmd_t             cmd_i,
  output gha_pkg::stat_t            stat_o,
  input  logic [gha_pkg::OpW-1:0]   in_op_i,
  input  logic [gha_pkg::IdW-1:0]   in_id_i,
  input  logic [gha_pkg::VerW-1:0]  in_ver_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [gha_pkg::StW-1:0]   out_status_o,
  output logic [gha_pkg::IdW-1:0]   out_id_o,
  output logic [gha_pkg::VerW-1:0]  out_ver_o
);

  logic [gha_pkg::OpW-1:0]  op_q;
  logic [gha_pkg::IdW-1:0]  id_q;
  logic [gha_pkg::VerW-1:0] ver_q;
  logic [gha_pkg::CntW-1:0] free_count_q, free_count_d;
  logic [gha_pkg::CntW-1:0] next_unused_q, next_unused_d;
  logic [gha_pkg::CntW-1:0] count_dec;
  logic                     out_valid_q;
  logic [gha_pkg::StW-1:0]  out_status_q;
  logic [gha_pkg::IdW-1:0]  out_id_q;
  logic [gha_pkg::VerW-1:0] out_ver_q;
  logic                     out_free;

  logic [gha_pkg::IdW-1:0]  stk_rdata;
  logic [gha_pkg::VerW-1:0] ver_rdata;
  logic [gha_pkg::VerW-1:0] ver_inc;
  logic                     ver_we;
  logic [gha_pkg::IdW-1:0]  ver_waddr;
  logic [gha_pkg::VerW-1:0] ver_wdata;
  logic [gha_pkg::IdW-1:0]  ver_raddr;

  gha_pkg::status_e         res_status;
  logic [gha_pkg::IdW-1:0]  res_id;
  logic [gha_pkg::VerW-1:0] res_ver;
  logic                     commit_fresh;
  logic                     commit_free;
  logic                     commit_pop;

  assign count_dec = free_count_q - gha_pkg::CntOne;
  assign ver_inc   = ver_rdata + gha_pkg::VerW'(1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_op_i;
      id_q  <= in_id_i;
      ver_q <= in_ver_i;
    end
  end

  // Form the result; state changes only when it is loaded into the output stage
  always_comb begin
    res_status   = gha_pkg::ST_BAD;
    res_id       = id_q;
    res_ver      = '0;
    commit_fresh = 1'b0;
    commit_free  = 1'b0;
    commit_pop   = 1'b0;
    case (cmd_i.res_sel)
      gha_pkg::RES_FRESH: begin
        res_status   = gha_pkg::ST_OK;
        res_id       = next_unused_q[gha_pkg::IdW-1:0];
        commit_fresh = cmd_i.res_load;
      end
      gha_pkg::RES_EMPTY: begin
        res_status = gha_pkg::ST_EMPTY;
        res_id     = '0;
      end
      gha_pkg::RES_POP: begin
        res_status = gha_pkg::ST_OK;
        res_id     = stk_rdata;
        res_ver    = ver_rdata;
        commit_pop = cmd_i.res_load;
      end
      gha_pkg::RES_CHECK: begin
        res_ver = ver_rdata;
        if (ver_rdata == ver_q) begin
          if (op_q == gha_pkg::OP_VALIDATE) begin
            res_status = gha_pkg::ST_OK;
          end else if (free_count_q < gha_pkg::MaxCount) begin
            res_status  = gha_pkg::ST_OK;
            res_ver     = ver_inc;
            commit_free = cmd_i.res_load;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    free_count_d  = free_count_q;
    next_unused_d = next_unused_q;
    if (commit_pop) begin
      free_count_d = count_dec;
    end else if (commit_free) begin
      free_count_d = free_count_q + gha_pkg::CntOne;
    end
    if (commit_fresh) begin
      next_unused_d = next_unused_q + gha_pkg::CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q  <= '0;
      next_unused_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      free_count_q  <= free_count_d;
      next_unused_q <= next_unused_d;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_ver_q    <= res_ver;
    end
  end

  // A fresh id gets its version entry cleared as it is issued
  assign ver_we    = commit_fresh || commit_free;
  assign ver_waddr = commit_fresh ? next_unused_q[gha_pkg::IdW-1:0] : id_q;
  assign ver_wdata = commit_fresh ? '0 : ver_inc;
  assign ver_raddr = cmd_i.ver_rd_pop ? stk_rdata : id_q;

  gha_ram #(
    .Width (gha_pkg::IdW),
    .Depth (gha_pkg::MaxIds)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (commit_free),
    .waddr_i (free_count_q[gha_pkg::IdW-1:0]),
    .wdata_i (id_q),
    .re_i    (cmd_i.stack_rd),
    .raddr_i (count_dec[gha_pkg::IdW-1:0]),
    .rdata_o (stk_rdata)
  );

  gha_ram #(
    .Width (gha_pkg::VerW),
    .Depth (gha_pkg::MaxIds)
  ) u_ver_ram (
    .clk_i   (clk_i),
    .we_i    (ver_we),
    .waddr_i (ver_waddr),
    .wdata_i (ver_wdata),
    .re_i    (cmd_i.ver_rd_pop || cmd_i.ver_rd_id),
    .raddr_i (ver_raddr),
    .rdata_o (ver_rdata)
  );

  assign stat_o.op          = op_q;
  assign stat_o.stack_empty = (free_count_q == '0);
  assign stat_o.fresh_avail = (next_unused_q < gha_pkg::MaxCount);
  assign stat_o.issued      = ({1'b0, id_q} < next_unused_q);
  assign stat_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_ver_o    = out_ver_q;

endmodule

FILE: rtl/core/gha_ctrl.sv
module gha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gha_pkg::stat_t stat_i,
  output gha_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_STK  = 4'b0100,
    S_RES  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  gha_pkg::res_e   res_sel_q, res_sel_d;

  always_comb begin
    state_d       = state_q;
    res_sel_d     = res_sel_q;
    cmd_o         = '0;
    cmd_o.res_sel = res_sel_q;
    in_ready_o    = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        state_d   = S_RES;
        res_sel_d = gha_pkg::RES_BAD;
        case (stat_i.op)
          gha_pkg::OP_ALLOC: begin
            if (!stat_i.stack_empty) begin
              cmd_o.stack_rd = 1'b1;
              res_sel_d      = gha_pkg::RES_POP;
              state_d        = S_STK;
            end else if (stat_i.fresh_avail) begin
              res_sel_d = gha_pkg::RES_FRESH;
            end else begin
              res_sel_d = gha_pkg::RES_EMPTY;
            end
          end
          gha_pkg::OP_FREE, gha_pkg::OP_VALIDATE: begin
            if (stat_i.issued) begin
              cmd_o.ver_rd_id = 1'b1;
              res_sel_d       = gha_pkg::RES_CHECK;
            end
          end
          default: begin
          end
        endcase
      end
      S_STK: begin
        // popped id is on the stack read port; fetch its version
        cmd_o.ver_rd_pop = 1'b1;
        state_d          = S_RES;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_sel_q <= gha_pkg::RES_BAD;
    end else begin
      state_q   <= state_d;
      res_sel_q <= res_sel_d;
    end
  end

endmodule
